[rtl/sanh_pkg.sv]
// Shared constants and arithmetic helpers for the sphere avoidance nearest-hit block.
package sanh_pkg;

  localparam int unsigned UnitBits = 30;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned WideW    = 36;

  // A positive projection is capped one below all ones, which marks "no hit".
  localparam logic [33:0] TCap = 34'h0_FFFF_FFFE;

  // Saturate a wide signed value to the signed 32-bit coordinate range.
  function automatic logic [CoordW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic [CoordW-1:0] r;
    if (v > $signed(36'sh0_7FFF_FFFF)) begin
      r = 32'h7FFF_FFFF;
    end else if (v < $signed(36'shF_8000_0000)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  // Magnitude of p / 2^30, rounded to nearest with ties away from zero.
  function automatic logic [33:0] rnd_mag(input logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] s;
    m = p[63] ? (64'd0 - p) : p;
    s = m + (64'd1 << (UnitBits - 1));
    return s[63:UnitBits];
  endfunction

endpackage

[rtl/sphere_avoidance_nearest_hit.sv]
// Top level: sequential nearest-hit test of spheres with bit-serial root and divider.
// Throughput: one sphere at a time; up to six bit-serial divisions (a load and 31 steps
// each) and up to two bit-serial square roots (32 steps each) run for a sphere with a goal.
// Reset: margin 0, nearest distance all ones, no hit, avoidance point zero.
module sphere_avoidance_nearest_hit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] char_pos_x_i,
  input  logic signed [31:0] char_pos_y_i,
  input  logic signed [31:0] char_pos_z_i,
  input  logic signed [31:0] goal_x_i,
  input  logic signed [31:0] goal_y_i,
  input  logic signed [31:0] goal_z_i,
  input  logic               goal_valid_i,
  input  logic signed [31:0] sphere_center_x_i,
  input  logic signed [31:0] sphere_center_y_i,
  input  logic signed [31:0] sphere_center_z_i,
  input  logic [30:0]        sphere_radius_i,
  input  logic               last_sphere_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        nearest_distance_o,
  output logic               hit_o,
  output logic signed [31:0] avoid_x_o,
  output logic signed [31:0] avoid_y_o,
  output logic signed [31:0] avoid_z_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DSQ, S_SQ1, S_NDIV, S_CDOT, S_CSQ, S_TSQ, S_RSQ,
    S_V, S_VSQ, S_SQ2, S_UDIV, S_AV, S_UPD, S_FIN
  } state_e;

  state_e             state_q;
  logic               ph_q;
  logic [1:0]         i_q;
  logic [5:0]         cnt_q;
  logic [30:0]        margin_q;

  logic signed [31:0] d_q  [3];
  logic signed [31:0] c_q  [3];
  logic signed [31:0] ce_q [3];
  logic signed [31:0] n_q  [3];
  logic [31:0]        vm_q [3];
  logic [2:0]         vneg_q;
  logic [31:0]        npt_q [3];
  logic [31:0]        rr_q;
  logic               last_q;
  logic [31:0]        t_q;
  logic [31:0]        len_q;
  logic [63:0]        acc_q;
  logic signed [63:0] mul_p_q;

  logic [63:0]        sq_x_q;
  logic [33:0]        sq_rem_q;
  logic [31:0]        sq_root_q;

  logic [30:0]        dv_num_q;
  logic [31:0]        dv_rem_q;
  logic [30:0]        dv_quo_q;
  logic               dv_neg_q;

  logic [31:0]        best_q;
  logic               any_hit_q;
  logic [31:0]        pt_q [3];

  logic               out_valid_q;
  logic [31:0]        out_dist_q;
  logic               out_hit_q;
  logic [31:0]        out_pt_q [3];

  // Shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  logic [63:0]        acc_add;
  logic [33:0]        rmag;
  logic [33:0]        tmag;
  logic               tneg;
  logic [31:0]        tcap;
  logic signed [35:0] rs36;
  logic signed [35:0] v36;
  logic [35:0]        vabs;
  logic signed [35:0] av36;
  logic [64:0]        vsum;
  logic [31:0]        dabs;
  logic [31:0]        dv_m;
  logic [63:0]        dv_load;
  logic [32:0]        dv_rem2;
  logic [32:0]        dv_diff;
  logic               dv_ge;
  logic [31:0]        dv_rem_n;
  logic [30:0]        dv_quo_n;
  logic [31:0]        dv_res;
  logic [35:0]        sq_rem2;
  logic [35:0]        sq_trial;
  logic [35:0]        sq_diff;
  logic               sq_ge;
  logic [33:0]        sq_rem_n;
  logic [31:0]        sq_root_n;

  logic               in_fire;
  logic               cfg_wr;
  logic               out_load;

  assign pready     = 1'b1;
  assign prdata     = paddr[2] ? 32'd0 : {1'b0, margin_q};
  assign cfg_wr     = psel & penable & pwrite;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == S_FIN) && last_q && (!out_valid_q || out_ready_i);

  assign out_valid_o        = out_valid_q;
  assign nearest_distance_o = out_dist_q;
  assign hit_o              = out_hit_q;
  assign avoid_x_o          = out_pt_q[0];
  assign avoid_y_o          = out_pt_q[1];
  assign avoid_z_o          = out_pt_q[2];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DSQ: begin
        mul_a = {d_q[i_q][31], d_q[i_q]};
        mul_b = {d_q[i_q][31], d_q[i_q]};
      end
      S_CDOT: begin
        mul_a = {c_q[i_q][31], c_q[i_q]};
        mul_b = {n_q[i_q][31], n_q[i_q]};
      end
      S_CSQ: begin
        mul_a = {c_q[i_q][31], c_q[i_q]};
        mul_b = {c_q[i_q][31], c_q[i_q]};
      end
      S_TSQ: begin
        mul_a = {1'b0, t_q};
        mul_b = {1'b0, t_q};
      end
      S_RSQ: begin
        mul_a = {1'b0, rr_q};
        mul_b = {1'b0, rr_q};
      end
      S_V: begin
        mul_a = {n_q[i_q][31], n_q[i_q]};
        mul_b = {1'b0, t_q};
      end
      S_VSQ: begin
        mul_a = {1'b0, vm_q[i_q]};
        mul_b = {1'b0, vm_q[i_q]};
      end
      S_AV: begin
        mul_a = {n_q[i_q][31], n_q[i_q]};
        mul_b = {1'b0, rr_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    acc_add = acc_q + mul_p_q;
    rmag    = sanh_pkg::rnd_mag(mul_p_q);
    tmag    = sanh_pkg::rnd_mag(acc_add);
    tneg    = acc_add[63] && (tmag != 34'd0);
    tcap    = (tmag > sanh_pkg::TCap) ? sanh_pkg::TCap[31:0] : tmag[31:0];
    rs36    = mul_p_q[63] ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
    v36     = rs36 - $signed({{4{c_q[i_q][31]}}, c_q[i_q]});
    vabs    = v36[35] ? (36'd0 - v36) : v36;
    av36    = $signed({{4{ce_q[i_q][31]}}, ce_q[i_q]}) + rs36;
    vsum    = {1'b0, acc_q} + {1'b0, mul_p_q};
    dabs    = d_q[i_q][31] ? (32'd0 - d_q[i_q]) : d_q[i_q];

    dv_m     = (state_q == S_NDIV) ? dabs : vm_q[i_q];
    dv_load  = {2'b00, dv_m, 30'd0} + {33'd0, len_q[31:1]};
    dv_rem2  = {dv_rem_q, dv_num_q[30]};
    dv_diff  = dv_rem2 - {1'b0, len_q};
    dv_ge    = (dv_rem2 >= {1'b0, len_q});
    dv_rem_n = dv_ge ? dv_diff[31:0] : dv_rem2[31:0];
    dv_quo_n = {dv_quo_q[29:0], dv_ge};
    dv_res   = dv_neg_q ? (32'd0 - {1'b0, dv_quo_n}) : {1'b0, dv_quo_n};

    sq_rem2   = {sq_rem_q, sq_x_q[63:62]};
    sq_trial  = {2'b00, sq_root_q, 2'b01};
    sq_diff   = sq_rem2 - sq_trial;
    sq_ge     = (sq_rem2 >= sq_trial);
    sq_rem_n  = sq_ge ? sq_diff[33:0] : sq_rem2[33:0];
    sq_root_n = {sq_root_q[30:0], sq_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= 1'b0;
      i_q         <= 2'd0;
      cnt_q       <= 6'd0;
      margin_q    <= '0;
      best_q      <= '1;
      any_hit_q   <= 1'b0;
      pt_q[0]     <= '0;
      pt_q[1]     <= '0;
      pt_q[2]     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr && !paddr[2]) begin
        margin_q <= pwdata[30:0];
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            d_q[0]  <= sanh_pkg::sat32($signed({{4{goal_x_i[31]}}, goal_x_i})
                       - $signed({{4{char_pos_x_i[31]}}, char_pos_x_i}));
            d_q[1]  <= sanh_pkg::sat32($signed({{4{goal_y_i[31]}}, goal_y_i})
                       - $signed({{4{char_pos_y_i[31]}}, char_pos_y_i}));
            d_q[2]  <= sanh_pkg::sat32($signed({{4{goal_z_i[31]}}, goal_z_i})
                       - $signed({{4{char_pos_z_i[31]}}, char_pos_z_i}));
            c_q[0]  <= sanh_pkg::sat32(
                       $signed({{4{sphere_center_x_i[31]}}, sphere_center_x_i})
                       - $signed({{4{char_pos_x_i[31]}}, char_pos_x_i}));
            c_q[1]  <= sanh_pkg::sat32(
                       $signed({{4{sphere_center_y_i[31]}}, sphere_center_y_i})
                       - $signed({{4{char_pos_y_i[31]}}, char_pos_y_i}));
            c_q[2]  <= sanh_pkg::sat32(
                       $signed({{4{sphere_center_z_i[31]}}, sphere_center_z_i})
                       - $signed({{4{char_pos_z_i[31]}}, char_pos_z_i}));
            ce_q[0] <= sphere_center_x_i;
            ce_q[1] <= sphere_center_y_i;
            ce_q[2] <= sphere_center_z_i;
            rr_q    <= {1'b0, margin_q} + {1'b0, sphere_radius_i};
            last_q  <= last_sphere_i;
            acc_q   <= '0;
            i_q     <= 2'd0;
            ph_q    <= 1'b0;
            state_q <= goal_valid_i ? S_DSQ : S_FIN;
          end
        end

        S_DSQ: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q  <= 1'b0;
            acc_q <= acc_add;
            if (i_q == 2'd2) begin
              i_q <= 2'd0;
              if (acc_add == 64'd0) begin
                // Goal on the character: no direction, so no hit.
                state_q <= S_FIN;
              end else begin
                sq_x_q    <= acc_add;
                sq_rem_q  <= '0;
                sq_root_q <= '0;
                cnt_q     <= 6'd0;
                state_q   <= S_SQ1;
              end
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end

        S_SQ1, S_SQ2: begin
          sq_x_q    <= {sq_x_q[61:0], 2'b00};
          sq_rem_q  <= sq_rem_n;
          sq_root_q <= sq_root_n;
          cnt_q     <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            len_q <= sq_root_n;
            i_q   <= 2'd0;
            ph_q  <= 1'b0;
            if (state_q == S_SQ1) begin
              state_q <= S_NDIV;
            end else if (sq_root_n == 32'd0) begin
              // Centre lies on the path: the avoidance point is the centre.
              npt_q[0] <= ce_q[0];
              npt_q[1] <= ce_q[1];
              npt_q[2] <= ce_q[2];
              state_q  <= S_UPD;
            end else begin
              state_q <= S_UDIV;
            end
          end
        end

        S_NDIV, S_UDIV: begin
          if (!ph_q) begin
            dv_rem_q <= dv_load[62:31];
            dv_num_q <= dv_load[30:0];
            dv_quo_q <= '0;
            dv_neg_q <= (state_q == S_NDIV) ? d_q[i_q][31] : vneg_q[i_q];
            cnt_q    <= 6'd0;
            ph_q     <= 1'b1;
          end else begin
            dv_rem_q <= dv_rem_n;
            dv_num_q <= {dv_num_q[29:0], 1'b0};
            dv_quo_q <= dv_quo_n;
            cnt_q    <= cnt_q + 6'd1;
            if (cnt_q == 6'd30) begin
              n_q[i_q] <= dv_res;
              ph_q     <= 1'b0;
              if (i_q == 2'd2) begin
                i_q     <= 2'd0;
                acc_q   <= '0;
                state_q <= (state_q == S_NDIV) ? S_CDOT : S_AV;
              end else begin
                i_q <= i_q + 2'd1;
              end
            end
          end
        end

        S_CDOT: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (i_q == 2'd2) begin
              i_q   <= 2'd0;
              acc_q <= '0;
              t_q   <= tcap;
              // Behind the character or beyond the nearest hit so far.
              state_q <= (tneg || (tcap > best_q)) ? S_FIN : S_CSQ;
            end else begin
              acc_q <= acc_add;
              i_q   <= i_q + 2'd1;
            end
          end
        end

        S_CSQ: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q  <= 1'b0;
            acc_q <= acc_add;
            if (i_q == 2'd2) begin
              i_q     <= 2'd0;
              state_q <= S_TSQ;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end

        S_TSQ: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q    <= 1'b0;
            acc_q   <= (acc_q > $unsigned(mul_p_q)) ? (acc_q - mul_p_q) : 64'd0;
            state_q <= S_RSQ;
          end
        end

        S_RSQ: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q    <= 1'b0;
            state_q <= (acc_q > $unsigned(mul_p_q)) ? S_FIN : S_V;
          end
        end

        S_V: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q          <= 1'b0;
            vneg_q[i_q]   <= v36[35];
            vm_q[i_q]     <= (vabs > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : vabs[31:0];
            if (i_q == 2'd2) begin
              i_q     <= 2'd0;
              acc_q   <= '0;
              state_q <= S_VSQ;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end

        S_VSQ: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q  <= 1'b0;
            acc_q <= vsum[64] ? '1 : vsum[63:0];
            if (i_q == 2'd2) begin
              i_q       <= 2'd0;
              sq_x_q    <= vsum[64] ? '1 : vsum[63:0];
              sq_rem_q  <= '0;
              sq_root_q <= '0;
              cnt_q     <= 6'd0;
              state_q   <= S_SQ2;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end

        S_AV: begin
          if (!ph_q) begin
            mul_p_q <= prod[63:0];
            ph_q    <= 1'b1;
          end else begin
            ph_q       <= 1'b0;
            npt_q[i_q] <= sanh_pkg::sat32(av36);
            if (i_q == 2'd2) begin
              i_q     <= 2'd0;
              state_q <= S_UPD;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end

        S_UPD: begin
          best_q    <= t_q;
          any_hit_q <= 1'b1;
          pt_q[0]   <= npt_q[0];
          pt_q[1]   <= npt_q[1];
          pt_q[2]   <= npt_q[2];
          state_q   <= S_FIN;
        end

        S_FIN: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            // The kept state already reads as the no-hit result when nothing hit.
            out_valid_q <= 1'b1;
            out_dist_q  <= best_q;
            out_hit_q   <= any_hit_q;
            out_pt_q[0] <= pt_q[0];
            out_pt_q[1] <= pt_q[1];
            out_pt_q[2] <= pt_q[2];
            best_q      <= '1;
            any_hit_q   <= 1'b0;
            pt_q[0]     <= '0;
            pt_q[1]     <= '0;
            pt_q[2]     <= '0;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("input taken while a transaction is in progress");

  a_no_hit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_hit_q |-> (best_q == 32'hFFFF_FFFF) && (pt_q[0] == 32'd0))
    else $error("nearest distance or point changed without a hit");

  a_no_hit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (nearest_distance_o == 32'hFFFF_FFFF)
                                && (avoid_x_o == 32'sd0) && (avoid_z_o == 32'sd0))
    else $error("no-hit result carries a distance or a point");

  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SQ1) || (state_q == S_SQ2)) |-> (cnt_q < 6'd32))
    else $error("square root ran past its last step");

  a_upd_then_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (state_q == S_FIN) && any_hit_q)
    else $error("hit update did not complete");

endmodule
